/* hdl/iiel_pkg.sv */
// Shared widths, action codes and status codes for the indexed insert/erase list.
package iiel_pkg;

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 4;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic [ACTION_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DROP   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ERASE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

/* hdl/indexed_insert_erase_list.sv */
// Top level of the indexed insert/erase list: sequencer, entry count and result register.
//
// An ordered list of signed words held in a single-port-write RAM of CAPACITY entries.
// Every input beat carries one action (append, drop last, insert at index, erase at
// index, read at index, clear) and yields exactly one output beat with the word read,
// the entry count after the action and a status (ok, full, empty, index out of range).
// A failed action leaves the list untouched. Moving entries for insert and erase is
// done by a small sequencer that walks the RAM one entry at a time: each moved entry
// is read and then written on the RAM port. The input is not ready again until the
// sequencer has handed its result to the output register, so the RAM port and the
// shift walk set the throughput. The output register holds a result until it is
// taken, and a new beat may be accepted meanwhile. The capacity limit register
// (reset 16) is clamped to CAPACITY and only blocks growth; the user must write it
// through cfg_we and cfg_data only while the block is idle, as the block itself does
// not enforce this. No clearing pass is needed after reset, as only positions below
// the entry count are ever read.
module indexed_insert_erase_list
  import iiel_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // Configuration port
  input  logic                       cfg_we,
  input  logic [LIMIT_W-1:0]         cfg_data,
  // Input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ACTION_W-1:0]        action,
  input  logic [INDEX_W-1:0]         index,
  input  logic signed [VALUE_W-1:0]  value,
  // Output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  read_value,
  output logic [COUNT_W-1:0]         count,
  output logic [STATUS_W-1:0]        status
);

  // Widths that follow from the store size.
  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int LW   = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int OCW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int EW   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                 state;
  logic [CW-1:0]          entry_count;
  logic [LIMIT_W-1:0]     capacity_limit;
  logic [ACTION_W-1:0]    op;
  logic [AW-1:0]          ptr;
  logic [AW-1:0]          idx_q;
  logic [DATA_WIDTH-1:0]  word_q;
  logic signed [VALUE_W-1:0] res_read;
  logic [STATUS_W-1:0]    res_status;

  // RAM port signals.
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DATA_WIDTH-1:0]  ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  // Checks made on the beat being accepted.
  logic                   in_fire;
  logic [CMPW-1:0]        cnt_c;
  logic [CMPW-1:0]        idx_c;
  logic [LW-1:0]          lim_e;
  logic                   is_empty;
  logic                   is_full;
  logic signed [EW-1:0]   val_ext;
  logic [DATA_WIDTH-1:0]  word_in;
  logic signed [DATA_WIDTH-1:0] rdata_s;
  logic signed [EW-1:0]   rd_ext;
  logic [OCW-1:0]         count_wide;
  logic [AW-1:0]          ptr_dec;
  logic [AW-1:0]          ptr_inc;
  logic                   erase_more;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign cnt_c    = CMPW'(entry_count);
  assign idx_c    = CMPW'(index);
  // The limit is clamped to the size of the store.
  assign lim_e    = (LW'(capacity_limit) > LW'(CAPACITY)) ? LW'(CAPACITY)
                                                          : LW'(capacity_limit);
  assign is_empty = (entry_count == '0);
  assign is_full  = (LW'(entry_count) >= lim_e);

  // The input word is sign-extended from 32 bits, then cut to the stored width;
  // a stored word is sign-extended back and cut to 32 bits on the way out.
  assign val_ext  = EW'(value);
  assign word_in  = val_ext[DATA_WIDTH-1:0];
  assign rdata_s  = ram_rdata;
  assign rd_ext   = EW'(rdata_s);

  assign count_wide = OCW'(entry_count);

  assign ptr_dec    = ptr - AW'(1);
  assign ptr_inc    = ptr + AW'(1);
  // During an erase walk, another entry still has to come down when ptr+2 < count.
  assign erase_more = ((CW + 1)'(ptr) + (CW + 1)'(2)) < (CW + 1)'(entry_count);

  // RAM port control: appends write straight away, shifts read then write,
  // and an insert finally places the new word at its index.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ptr;
    case (state)
      S_IDLE: begin
        if (in_fire && action == ACT_APPEND && !is_full) begin
          ram_we    = 1'b1;
          ram_waddr = entry_count[AW-1:0];
          ram_wdata = word_in;
        end
      end
      S_RD: begin
        ram_re = 1'b1;
        if (op == ACT_INSERT) begin
          ram_raddr = ptr_dec;
        end else if (op == ACT_ERASE) begin
          ram_raddr = ptr_inc;
        end
      end
      S_WR: begin
        ram_we = (op == ACT_INSERT) || (op == ACT_ERASE);
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = word_q;
      end
      default: begin
      end
    endcase
  end

  iiel_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      capacity_limit <= cfg_data;
    end
  end

  // Sequencer. Checks are made on acceptance; only a successful insert, erase or
  // read goes on to walk the RAM.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      op          <= ACT_APPEND;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op         <= action;
            word_q     <= word_in;
            idx_q      <= idx_c[AW-1:0];
            ptr        <= idx_c[AW-1:0];
            res_read   <= '0;
            res_status <= ST_OK;
            state      <= S_DONE;
            case (action)
              ACT_APPEND: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  entry_count <= entry_count + CW'(1);
                end
              end
              ACT_DROP: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  entry_count <= entry_count - CW'(1);
                end
              end
              ACT_INSERT: begin
                if (idx_c > cnt_c) begin
                  res_status <= ST_RANGE;
                end else if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  ptr   <= entry_count[AW-1:0];
                  state <= (idx_c == cnt_c) ? S_PUT : S_RD;
                end
              end
              ACT_ERASE: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else if (idx_c >= cnt_c) begin
                  res_status <= ST_RANGE;
                end else if ((idx_c + CMPW'(1)) < cnt_c) begin
                  state <= S_RD;
                end else begin
                  entry_count <= entry_count - CW'(1);
                end
              end
              ACT_READ: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else if (idx_c >= cnt_c) begin
                  res_status <= ST_RANGE;
                end else begin
                  state <= S_RD;
                end
              end
              ACT_CLEAR: begin
                entry_count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          case (op)
            ACT_INSERT: begin
              ptr   <= ptr_dec;
              state <= (ptr_dec == idx_q) ? S_PUT : S_RD;
            end
            ACT_ERASE: begin
              ptr <= ptr_inc;
              if (erase_more) begin
                state <= S_RD;
              end else begin
                entry_count <= entry_count - CW'(1);
                state       <= S_DONE;
              end
            end
            default: begin
              res_read <= rd_ext[VALUE_W-1:0];
              state    <= S_DONE;
            end
          endcase
        end
        S_PUT: begin
          entry_count <= entry_count + CW'(1);
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: a result waits here until the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid  <= 1'b1;
      read_value <= res_read;
      count      <= count_wide[COUNT_W-1:0];
      status     <= res_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // An accepted beat always leaves the input not ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input still ready after acceptance");

  // A clear empties the list.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_fire && action == ACT_CLEAR |=> entry_count == '0)
    else $error("clear did not empty the list");

  // The entry count never exceeds the store.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(entry_count) <= (CW + 1)'(CAPACITY))
    else $error("entry count beyond capacity");

  // A failed action never returns a word.
  a_fail_no_word: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && res_status != ST_OK |-> res_read == '0)
    else $error("failed action returned a word");

endmodule

/* hdl/iiel_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module iiel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
